// File: rtl/core/wav_header_duration_parser_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef WAV_HEADER_DURATION_PARSER_MACROS_SVH
`define WAV_HEADER_DURATION_PARSER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define WHDP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("whdp check failed");

// Next-cycle implication, held off during reset.
`define WHDP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("whdp check failed");

`endif

// File: rtl/core/whdp_pkg.sv
package whdp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;
  localparam logic [2:0] ST_ZERO_RATE = 3'd5;

  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN = 32'd16;
  localparam logic [15:0] FMT_PCM = 16'd1;

  typedef enum logic [3:0] {
    PH_RIFF, PH_HSIZE, PH_WAVE, PH_CKID, PH_SZ_FMT, PH_SZ_DATA,
    PH_SZ_OTHER, PH_FMT_BODY, PH_SKIP, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    SQ_RUN, SQ_MUL1, SQ_MUL2, SQ_CHK, SQ_DIV, SQ_OUT
  } seq_t;

  typedef struct packed {
    logic       shift;
    logic       idx_inc;
    logic       idx_clr;
    logic       size_take;
    logic       fmt_clear;
    logic       fmt_take;
    logic       data_take;
    logic       fmt_seen;
    logic       skip_size;
    logic       skip_fmt;
    logic       skip_step;
    logic       set_err;
    logic [2:0] err_code;
    logic       clear;
    logic       frame_calc;
    logic       product_calc;
    logic       status_load;
    logic [2:0] status_val;
    logic       div_start;
    logic       div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic       riff_ok;
    logic       wave_ok;
    logic       idx_last4;
    logic       idx_last16;
    logic       id_fmt;
    logic       id_data;
    logic       size_ge16;
    logic       size_zero;
    logic       fmt_pcm;
    logic       fmt_rest_zero;
    logic       skip_done;
    logic       product_bad;
    logic       div_done;
    logic [2:0] error_code;
    logic       seen_fmt;
    logic       seen_data;
  } dp_stat_t;

  function automatic logic [7:0] riff_tag(input logic [1:0] i);
    logic [7:0] t;
    case (i)
      2'd0:    t = 8'h52;
      2'd1:    t = 8'h49;
      default: t = 8'h46;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] wave_tag(input logic [1:0] i);
    logic [7:0] t;
    case (i)
      2'd0:    t = 8'h57;
      2'd1:    t = 8'h41;
      2'd2:    t = 8'h56;
      default: t = 8'h45;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/whdp_ctrl.sv
module whdp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              end_of_file,
  input  logic              out_stall,
  input  whdp_pkg::dp_stat_t stat,
  output whdp_pkg::dp_cmd_t  cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import whdp_pkg::*;

  phase_t     phase, phase_next;
  seq_t       seq, seq_next;
  logic       acc;
  logic [2:0] pre_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      seq   <= SQ_RUN;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

  assign in_stall  = (seq != SQ_RUN);
  assign out_valid = (seq == SQ_OUT);
  assign acc       = in_valid && !in_stall;

  // status implied by a recorded error or by where parsing stopped
  always_comb begin
    if (stat.error_code != ST_OK) begin
      pre_status = stat.error_code;
    end else begin
      case (phase)
        PH_RIFF, PH_HSIZE, PH_WAVE:           pre_status = ST_BAD_HDR;
        PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER:   pre_status = ST_TRUNC;
        PH_FMT_BODY:                          pre_status = ST_BAD_FMT;
        default: begin
          pre_status = (stat.seen_fmt && stat.seen_data) ? ST_OK : ST_MISSING;
        end
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    seq_next   = seq;
    cmd        = '0;
    unique case (seq)
      SQ_RUN: begin
        if (acc) begin
          if (end_of_file) seq_next = SQ_MUL1;
          unique case (phase)
            PH_RIFF, PH_WAVE: begin
              if ((phase == PH_RIFF) ? !stat.riff_ok : !stat.wave_ok) begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_BAD_HDR;
                phase_next   = PH_HALT;
              end else begin
                cmd.idx_inc = 1'b1;
                if (stat.idx_last4) begin
                  cmd.idx_clr = 1'b1;
                  phase_next  = (phase == PH_RIFF) ? PH_HSIZE : PH_CKID;
                end
              end
            end
            PH_HSIZE: begin
              cmd.idx_inc = 1'b1;
              if (stat.idx_last4) begin
                cmd.idx_clr = 1'b1;
                phase_next  = PH_WAVE;
              end
            end
            PH_CKID: begin
              cmd.shift   = 1'b1;
              cmd.idx_inc = 1'b1;
              if (stat.idx_last4) begin
                cmd.idx_clr = 1'b1;
                if (stat.id_fmt)       phase_next = PH_SZ_FMT;
                else if (stat.id_data) phase_next = PH_SZ_DATA;
                else                   phase_next = PH_SZ_OTHER;
              end
            end
            PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
              cmd.shift   = 1'b1;
              cmd.idx_inc = 1'b1;
              if (stat.idx_last4) begin
                cmd.idx_clr   = 1'b1;
                cmd.size_take = 1'b1;
                if (phase == PH_SZ_FMT && stat.size_ge16) begin
                  cmd.fmt_clear = 1'b1;
                  phase_next    = PH_FMT_BODY;
                end else begin
                  cmd.data_take = (phase == PH_SZ_DATA);
                  cmd.skip_size = 1'b1;
                  phase_next    = stat.size_zero ? PH_CKID : PH_SKIP;
                end
              end
            end
            PH_FMT_BODY: begin
              cmd.fmt_take = 1'b1;
              cmd.idx_inc  = 1'b1;
              if (stat.idx_last16) begin
                cmd.idx_clr = 1'b1;
                if (!stat.fmt_pcm) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_BAD_FMT;
                  phase_next   = PH_HALT;
                end else begin
                  cmd.fmt_seen = 1'b1;
                  cmd.skip_fmt = 1'b1;
                  phase_next   = stat.fmt_rest_zero ? PH_CKID : PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              cmd.skip_step = 1'b1;
              if (stat.skip_done) phase_next = PH_CKID;
            end
            default: ;
          endcase
        end
      end
      SQ_MUL1: begin
        cmd.frame_calc = 1'b1;
        seq_next       = SQ_MUL2;
      end
      SQ_MUL2: begin
        cmd.product_calc = 1'b1;
        seq_next         = SQ_CHK;
      end
      SQ_CHK: begin
        cmd.status_load = 1'b1;
        if (pre_status != ST_OK) begin
          cmd.status_val = pre_status;
          seq_next       = SQ_OUT;
        end else if (stat.product_bad) begin
          cmd.status_val = ST_ZERO_RATE;
          seq_next       = SQ_OUT;
        end else begin
          cmd.status_val = ST_OK;
          cmd.div_start  = 1'b1;
          seq_next       = SQ_DIV;
        end
      end
      SQ_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) seq_next = SQ_OUT;
      end
      SQ_OUT: begin
        if (!out_stall) begin
          cmd.clear  = 1'b1;
          phase_next = PH_RIFF;
          seq_next   = SQ_RUN;
        end
      end
      default: seq_next = SQ_RUN;
    endcase
  end

endmodule

// File: rtl/core/whdp_dp.sv
module whdp_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         file_byte,
  input  whdp_pkg::dp_cmd_t  cmd,
  output whdp_pkg::dp_stat_t stat,
  output logic [2:0]         status,
  output logic [47:0]        duration_fixed,
  output logic [15:0]        channel_count,
  output logic [31:0]        sample_rate,
  output logic [15:0]        sample_bits,
  output logic [31:0]        data_length
);
  import whdp_pkg::*;

  logic [3:0]       idx;
  logic [31:0]      shift_word, shift_next;
  logic [31:0]      cur_size;
  logic [31:0]      skip_rem;
  logic             pad;
  logic [15:0]      format_code;
  logic [15:0]      held_channels;
  logic [31:0]      held_rate;
  logic [15:0]      held_bits;
  logic [31:0]      held_data_length;
  logic [1:0]       seen;
  logic [2:0]       error_code;
  logic [2:0]       status_reg;
  logic [28:0]      frame;
  logic [31:0]      product;
  logic [32:0]      rem;
  logic [32:0]      trial;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      quo_wide;

  assign shift_next = {file_byte, shift_word[31:8]};
  assign trial      = {rem[31:0], quo[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      idx              <= '0;
      shift_word       <= '0;
      cur_size         <= '0;
      skip_rem         <= '0;
      pad              <= 1'b0;
      format_code      <= '0;
      held_channels    <= '0;
      held_rate        <= '0;
      held_bits        <= '0;
      held_data_length <= '0;
      seen             <= '0;
      error_code       <= ST_OK;
      status_reg       <= ST_OK;
      cnt              <= '0;
    end else begin
      if (cmd.idx_clr)      idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 4'd1;
      if (cmd.shift) shift_word <= shift_next;
      if (cmd.size_take) begin
        cur_size <= shift_next;
        pad      <= shift_next[0];
      end
      if (cmd.fmt_clear) begin
        format_code   <= '0;
        held_channels <= '0;
        held_rate     <= '0;
        held_bits     <= '0;
      end
      if (cmd.fmt_take) begin
        case (idx)
          4'd0:  format_code[7:0]    <= file_byte;
          4'd1:  format_code[15:8]   <= file_byte;
          4'd2:  held_channels[7:0]  <= file_byte;
          4'd3:  held_channels[15:8] <= file_byte;
          4'd4:  held_rate[7:0]      <= file_byte;
          4'd5:  held_rate[15:8]     <= file_byte;
          4'd6:  held_rate[23:16]    <= file_byte;
          4'd7:  held_rate[31:24]    <= file_byte;
          4'd14: held_bits[7:0]      <= file_byte;
          4'd15: held_bits[15:8]     <= file_byte;
          default: ;
        endcase
      end
      if (cmd.data_take) begin
        held_data_length <= shift_next;
        seen[1]          <= 1'b1;
      end
      if (cmd.fmt_seen) seen[0] <= 1'b1;
      if (cmd.skip_size) skip_rem <= shift_next;
      if (cmd.skip_fmt)  skip_rem <= cur_size - FMT_MIN;
      if (cmd.skip_step) begin
        if (skip_rem != '0) skip_rem <= skip_rem - 32'd1;
        else                pad      <= 1'b0;
      end
      if (cmd.set_err)     error_code <= cmd.err_code;
      if (cmd.status_load) status_reg <= cmd.status_val;
      if (cmd.div_start)   cnt        <= CNT_W'(DIV_W);
      else if (cmd.div_step) cnt      <= cnt - CNT_W'(1);
    end
  end

  // multiply and restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.frame_calc)   frame   <= 29'(held_channels * held_bits[15:3]);
    if (cmd.product_calc) product <= 32'(frame * held_rate);
    if (cmd.div_start) begin
      rem <= '0;
      quo <= DIV_W'(held_data_length) << FRAC_BITS;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, product}) begin
        rem <= trial - {1'b0, product};
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    stat               = '0;
    stat.riff_ok       = (file_byte == riff_tag(idx[1:0]));
    stat.wave_ok       = (file_byte == wave_tag(idx[1:0]));
    stat.idx_last4     = (idx == 4'd3);
    stat.idx_last16    = (idx == 4'd15);
    stat.id_fmt        = (shift_next == ID_FMT);
    stat.id_data       = (shift_next == ID_DATA);
    stat.size_ge16     = (shift_next >= FMT_MIN);
    stat.size_zero     = (shift_next == '0);
    stat.fmt_pcm       = (format_code == FMT_PCM);
    stat.fmt_rest_zero = (cur_size == FMT_MIN);
    stat.skip_done     = (skip_rem == '0) || (skip_rem == 32'd1 && !pad);
    stat.product_bad   = (frame == '0) || (held_rate == '0) || (product == '0);
    stat.div_done      = (cnt == CNT_W'(1));
    stat.error_code    = error_code;
    stat.seen_fmt      = seen[0];
    stat.seen_data     = seen[1];
  end

  assign quo_wide       = 64'(quo);
  assign status         = status_reg;
  assign duration_fixed = (status_reg != ST_OK) ? 48'd0 :
                          (quo_wide[63:48] != '0) ? '1 : quo_wide[47:0];
  assign channel_count  = held_channels;
  assign sample_rate    = held_rate;
  assign sample_bits    = held_bits;
  assign data_length    = held_data_length;

endmodule

// File: rtl/core/wav_header_duration_parser.sv
// WAV header and duration parser. Feed the file one byte per item, with
// end_of_file set on the last byte. The RIFF/WAVE header is checked, chunks
// are walked by their little-endian sizes, a PCM fmt chunk supplies channels,
// rate and bits, and the last data chunk supplies the byte count. While
// parsing, one byte is taken every cycle. After the last byte the block
// forms frame_bytes * rate with two multiplies in turn, picks the status,
// and, only when the status is ok, runs a restoring divider that yields
// one quotient bit per cycle into a quotient of 32 + FRAC_BITS bits (48
// by default); then the result item is offered, and in_stall stays high
// until it has been taken. status: 0 ok, 1 bad header, 2 truncated size,
// 3 bad fmt, 4 missing chunk, 5 zero frame, rate or product.
// duration_fixed is zero unless status is ok. After the result the block
// is ready for a new file.
module wav_header_duration_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] duration_fixed,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [15:0] sample_bits,
  output logic [31:0] data_length
);
  import whdp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // parse phases and end-of-file sequencing
  whdp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_file (end_of_file),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd),
    .in_stall    (in_stall),
    .out_valid   (out_valid)
  );

  // field registers, skip counter, multiplier and divider
  whdp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .file_byte      (file_byte),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .duration_fixed (duration_fixed),
    .channel_count  (channel_count),
    .sample_rate    (sample_rate),
    .sample_bits    (sample_bits),
    .data_length    (data_length)
  );

endmodule

// File: rtl/core/whdp_chk.sv
`include "wav_header_duration_parser_macros.svh"

module whdp_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_file,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [47:0] duration_fixed
);
  import whdp_pkg::*;

  `WHDP_ASSERT_IMP(a_no_input_with_result, out_valid, in_stall)
  `WHDP_ASSERT_IMP(a_status_range, out_valid, status <= ST_ZERO_RATE)
  `WHDP_ASSERT_IMP(a_err_no_duration, out_valid && status != ST_OK, duration_fixed == 48'd0)
  `WHDP_ASSERT_NXT(a_eof_stalls, in_valid && !in_stall && end_of_file, in_stall)
  `WHDP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))

endmodule

bind wav_header_duration_parser whdp_chk u_whdp_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .end_of_file    (end_of_file),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .duration_fixed (duration_fixed)
);
